### src/u2l_pkg.sv
// u2l_pkg: word types, queue control structs and the decode/fold functions
// of the utf-8 to latin-1 folding transcoder
// used by every module under src; depends on nothing
package u2l_pkg;

	localparam int unsigned RUN_MAX = 4;
	localparam int unsigned HOLD_DEPTH = 3;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_APOS = 8'h27;
	localparam logic [7:0] CH_STAR = 8'h2A;
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_LT = 8'h3C;
	localparam logic [7:0] CH_GT = 8'h3E;

	localparam logic [20:0] CP_NBSP = 21'h0000A0;
	localparam logic [20:0] CP_LATIN_END = 21'h000100;
	localparam logic [20:0] CP_LSQUO = 21'h002018;
	localparam logic [20:0] CP_RSQUO = 21'h002019;
	localparam logic [20:0] CP_RSQUO_REV = 21'h00201B;
	localparam logic [20:0] CP_LDQUO = 21'h00201C;
	localparam logic [20:0] CP_RDQUO = 21'h00201D;
	localparam logic [20:0] CP_ENDASH = 21'h002013;
	localparam logic [20:0] CP_EMDASH = 21'h002014;
	localparam logic [20:0] CP_MINUS = 21'h002212;
	localparam logic [20:0] CP_HELLIP = 21'h002026;
	localparam logic [20:0] CP_BULLET = 21'h002022;
	localparam logic [20:0] CP_BLACK_CIRCLE = 21'h0025CF;
	localparam logic [20:0] CP_RARR = 21'h002192;
	localparam logic [20:0] CP_LARR = 21'h002190;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_word_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
	} out_word_t;

	typedef struct packed {
		logic [2:0]                cnt;
		logic [RUN_MAX-1:0][7:0]   bytes;
	} run_t;

	typedef struct packed {
		logic valid;
		run_t run;
	} q_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic [1:0]      n;
		logic [2:0][7:0] b;
	} fold_t;

	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		if (b[7] == 1'b0)
			len = 3'd1;
		else if ((b & 8'hE0) == 8'hC0)
			len = 3'd2;
		else if ((b & 8'hF0) == 8'hE0)
			len = 3'd3;
		else if ((b & 8'hF8) == 8'hF0)
			len = 3'd4;
		else
			len = 3'd1;
		return len;
	endfunction

	function automatic logic [20:0] decode(input logic [3:0][7:0] w, input logic [2:0] len);
		logic [20:0] cp;
		case (len)
			3'd2: cp = {10'd0, w[0][4:0], w[1][5:0]};
			3'd3: cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
			3'd4: cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
			default: cp = {13'd0, w[0]};
		endcase
		return cp;
	endfunction

	function automatic fold_t fold_point(input logic [20:0] cp);
		fold_t f;
		f = '0;
		if (cp == CP_NBSP) begin
			f.n = 2'd1;
			f.b[0] = CH_SPACE;
		end else if (cp < CP_LATIN_END) begin
			f.n = 2'd1;
			f.b[0] = cp[7:0];
		end else begin
			case (cp) inside
				CP_LSQUO, CP_RSQUO, CP_RSQUO_REV: begin
					f.n = 2'd1;
					f.b[0] = CH_APOS;
				end
				CP_LDQUO, CP_RDQUO: begin
					f.n = 2'd1;
					f.b[0] = CH_DQUOTE;
				end
				CP_ENDASH, CP_EMDASH, CP_MINUS: begin
					f.n = 2'd1;
					f.b[0] = CH_DASH;
				end
				CP_HELLIP: begin
					f.n = 2'd3;
					f.b = {CH_DOT, CH_DOT, CH_DOT};
				end
				CP_BULLET, CP_BLACK_CIRCLE: begin
					f.n = 2'd1;
					f.b[0] = CH_STAR;
				end
				CP_RARR: begin
					f.n = 2'd2;
					f.b[0] = CH_DASH;
					f.b[1] = CH_GT;
				end
				CP_LARR: begin
					f.n = 2'd2;
					f.b[0] = CH_LT;
					f.b[1] = CH_DASH;
				end
				default: f.n = 2'd0;
			endcase
		end
		return f;
	endfunction

	// left to right parse of n bytes, short sequences fall back to one byte
	function automatic run_t build_run(input logic [3:0][7:0] seq, input logic [2:0] n);
		run_t r;
		fold_t f;
		logic [2:0] nxt;
		logic [2:0] len;
		logic [20:0] cp;
		logic [3:0][7:0] w;
		r = '0;
		nxt = 3'd0;
		for (int p = 0; p < RUN_MAX; p++) begin
			if (3'(p) == nxt && 3'(p) < n) begin
				len = lead_length(seq[p]);
				if (3'(p) + len > n)
					len = 3'd1;
				for (int k = 0; k < RUN_MAX; k++) begin
					if (p + k < RUN_MAX)
						w[k] = seq[p+k];
					else
						w[k] = '0;
				end
				cp = decode(w, len);
				f = fold_point(cp);
				for (int k = 0; k < 3; k++) begin
					if (2'(k) < f.n && r.cnt < 3'(RUN_MAX)) begin
						r.bytes[r.cnt[1:0]] = f.b[k];
						r.cnt = r.cnt + 3'd1;
					end
				end
				nxt = 3'(p) + len;
			end
		end
		return r;
	endfunction

endpackage

### src/u2l_front.sv
// u2l_front: accepts text words, holds an unfinished sequence and builds
// the latin-1 run for each word; depends on u2l_pkg
module u2l_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_stall,
	input  u2l_pkg::in_word_t  text_word,
	input  u2l_pkg::q_stat_t   q_stat,
	output u2l_pkg::q_push_t   push
);

	logic [u2l_pkg::HOLD_DEPTH-1:0][7:0] held_q;
	logic [1:0]                          held_cnt_q;
	logic                                accept;
	logic                                fire;
	logic [3:0][7:0]                     seq;
	u2l_pkg::run_t                       run;

	assign text_stall = q_stat.full;
	assign accept = text_valid && !q_stat.full;

	always_comb begin
		for (int i = 0; i < u2l_pkg::HOLD_DEPTH; i++) begin
			if (2'(i) == held_cnt_q)
				seq[i] = text_word.in_byte;
			else
				seq[i] = held_q[i];
		end
		seq[3] = text_word.in_byte;
	end

	always_comb begin
		if (text_word.end_of_text)
			fire = 1'b1;
		else if (held_cnt_q == 2'd0)
			fire = (u2l_pkg::lead_length(text_word.in_byte) == 3'd1);
		else
			fire = ({1'b0, held_cnt_q} + 3'd1 >= u2l_pkg::lead_length(held_q[0]));
	end

	assign run = u2l_pkg::build_run(seq, {1'b0, held_cnt_q} + 3'd1);

	assign push.valid = accept && fire && (run.cnt != 3'd0);
	assign push.run = run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
		end else if (accept) begin
			if (fire)
				held_cnt_q <= 2'd0;
			else
				held_cnt_q <= held_cnt_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !fire && held_cnt_q != 2'd3)
			held_q[held_cnt_q] <= text_word.in_byte;
	end

endmodule

### src/u2l_fifo.sv
// u2l_fifo: two-entry queue of latin-1 runs between front and back
// depends on u2l_pkg
module u2l_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  u2l_pkg::q_push_t push,
	input  logic             pop,
	output u2l_pkg::run_t    head,
	output u2l_pkg::q_stat_t q_stat
);

	u2l_pkg::run_t mem_q [2];
	logic          wr_ptr_q;
	logic          rd_ptr_q;
	logic [1:0]    count_q;
	logic          do_pop;

	assign do_pop = pop && (count_q != 2'd0);
	assign head = mem_q[rd_ptr_q];
	assign q_stat.full = (count_q == 2'd2);
	assign q_stat.empty = (count_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push.valid)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push.valid && !do_pop)
				count_q <= count_q + 2'd1;
			else if (!push.valid && do_pop)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid)
			mem_q[wr_ptr_q] <= push.run;
	end

endmodule

### src/u2l_back.sv
// u2l_back: serializes queued runs into latin-1 words through an output register
// depends on u2l_pkg
module u2l_back (
	input  logic               clk,
	input  logic               arst_n,
	input  u2l_pkg::run_t      head,
	input  u2l_pkg::q_stat_t   q_stat,
	output logic               pop,
	output logic               latin_valid,
	input  logic               latin_stall,
	output u2l_pkg::out_word_t latin_word
);

	logic [1:0]         idx_q;
	logic               valid_q;
	u2l_pkg::out_word_t word_q;
	logic               load;
	logic               last;

	assign load = !q_stat.empty && (!valid_q || !latin_stall);
	assign last = ({1'b0, idx_q} + 3'd1 == head.cnt);
	assign pop = load && last;
	assign latin_valid = valid_q;
	assign latin_word = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load)
				valid_q <= 1'b1;
			else if (!latin_stall)
				valid_q <= 1'b0;
			if (load) begin
				if (last)
					idx_q <= 2'd0;
				else
					idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			word_q.out_byte <= head.bytes[idx_q];
			word_q.run_last <= last;
		end
	end

endmodule

### src/utf8_to_latin1_fold_core.sv
// utf8_to_latin1_fold_core: top level of the utf-8 to latin-1 folding transcoder
// depends on u2l_pkg, u2l_front, u2l_fifo, u2l_back
//
//   channel  handshake                  payload               direction
//   text     text_valid / text_stall    u2l_pkg::in_word_t    into the block
//   latin    latin_valid / latin_stall  u2l_pkg::out_word_t   out of the block
//
// one text word accepted per cycle while text_stall is low; a run of k latin-1 words
// leaves through the run queue and the output register at one word per cycle while
// latin_stall is low, so runs of two or more words set the rate; text_stall rises when
// the two-entry run queue is full
// reset clears the held count, the run queue and the output valid
// latin_stall only holds the output register and, once the queue fills, the input
module utf8_to_latin1_fold_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               text_valid,
	output logic               text_stall,
	input  u2l_pkg::in_word_t  text_word,
	output logic               latin_valid,
	input  logic               latin_stall,
	output u2l_pkg::out_word_t latin_word
);

	u2l_pkg::q_push_t push;
	u2l_pkg::q_stat_t q_stat;
	u2l_pkg::run_t    head;
	logic             pop;

	u2l_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_word  (text_word),
		.q_stat     (q_stat),
		.push       (push)
	);

	u2l_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	u2l_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_stat      (q_stat),
		.pop         (pop),
		.latin_valid (latin_valid),
		.latin_stall (latin_stall),
		.latin_word  (latin_word)
	);

endmodule

### src/u2l_checker.sv
// u2l_checker: port-level assertions for utf8_to_latin1_fold_core, bound to the top
// depends on u2l_pkg
module u2l_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               text_valid,
	input logic               text_stall,
	input u2l_pkg::in_word_t  text_word,
	input logic               latin_valid,
	input logic               latin_stall,
	input u2l_pkg::out_word_t latin_word
);

	logic [1:0] run_pos_q;
	logic       out_take;

	assign out_take = latin_valid && !latin_stall;

	// words of the current run already taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			run_pos_q <= 2'd0;
		else if (out_take) begin
			if (latin_word.run_last)
				run_pos_q <= 2'd0;
			else
				run_pos_q <= run_pos_q + 2'd1;
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		latin_valid && latin_stall |=> latin_valid && $stable(latin_word))
		else $error("latin word changed while stalled");

	a_run_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_take && !latin_word.run_last |-> run_pos_q != 2'd3)
		else $error("run longer than four words");

	a_full_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> latin_valid)
		else $error("input stalled with no word offered");

	a_no_stall_unused: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_stall |=> latin_valid || !text_stall)
		else $error("input stalled without pending output");

endmodule

bind utf8_to_latin1_fold_core u2l_checker u_chk (.*);

### sim/tb_utf8_to_latin1_fold_core.sv
// tb_utf8_to_latin1_fold_core: self-checking bench for the utf-8 to latin-1 folding core
// directed byte table, then random well-formed, truncated and broken sequences, checked
// word by word against the table or a local fold model; depends on u2l_pkg and the core
module tb_utf8_to_latin1_fold_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 296;
	localparam int LIMIT_CYCLES = 200000;
	localparam int TAIL_CYCLES = 16;
	localparam int REPORT_MAX = 10;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_TOGGLE} rx_mode_t;

	typedef struct packed {
		logic [7:0]      b;
		logic            eot;
		logic            known;
		logic [2:0]      n;
		logic [3:0][7:0] r;
	} plan_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               text_valid = 1'b0;
	logic               text_stall;
	u2l_pkg::in_word_t  text_word = '0;
	logic               latin_valid;
	logic               latin_stall = 1'b0;
	u2l_pkg::out_word_t latin_word;

	plan_row_t          text_plan[$];
	u2l_pkg::out_word_t latin_due_q[$];

	// model state
	logic [7:0] held [3];
	logic [1:0] held_n = 2'd0;
	logic [2:0] want_len = 3'd0;

	int  next_idx = 0;
	int  n_acc = 0;
	int  burst_left = 1;
	int  gap_left = 0;
	int  n_eot = 0;
	int  n_backpressure = 0;
	int  n_latin = 0;
	int  n_bad = 0;
	int  n_holds = 0;
	int  n_cycles = 0;
	int  rx_cycle = 0;
	int  hold_left = 0;
	logic holding = 1'b0;
	logic tail = 1'b0;

	utf8_to_latin1_fold_core u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_word   (text_word),
		.latin_valid (latin_valid),
		.latin_stall (latin_stall),
		.latin_word  (latin_word)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [2:0] seq_len_of(input logic [7:0] b);
		if (!b[7])
			return 3'd1;
		if (b[7:5] == 3'b110)
			return 3'd2;
		if (b[7:4] == 4'b1110)
			return 3'd3;
		if (b[7:3] == 5'b11110)
			return 3'd4;
		return 3'd1;
	endfunction

	function automatic logic [20:0] point_of(input logic [3:0][7:0] s, input int at,
			input int len);
		case (len)
			2: return {10'd0, s[at][4:0], s[at+1][5:0]};
			3: return {5'd0, s[at][3:0], s[at+1][5:0], s[at+2][5:0]};
			4: return {s[at][2:0], s[at+1][5:0], s[at+2][5:0], s[at+3][5:0]};
			default: return {13'd0, s[at]};
		endcase
	endfunction

	task automatic add_char(input logic [7:0] ch, inout int n, inout logic [3:0][7:0] r);
		if (n < 4) begin
			r[n] = ch;
			n++;
		end
	endtask

	task automatic add_point(input logic [20:0] cp, inout int n, inout logic [3:0][7:0] r);
		if (cp == 21'h0000A0) begin
			add_char(8'h20, n, r);
		end else if (cp < 21'h000100) begin
			add_char(cp[7:0], n, r);
		end else begin
			case (cp)
				21'h002018, 21'h002019, 21'h00201B: add_char(8'h27, n, r);
				21'h00201C, 21'h00201D: add_char(8'h22, n, r);
				21'h002013, 21'h002014, 21'h002212: add_char(8'h2D, n, r);
				21'h002026: begin
					add_char(8'h2E, n, r);
					add_char(8'h2E, n, r);
					add_char(8'h2E, n, r);
				end
				21'h002022, 21'h0025CF: add_char(8'h2A, n, r);
				21'h002192: begin
					add_char(8'h2D, n, r);
					add_char(8'h3E, n, r);
				end
				21'h002190: begin
					add_char(8'h3C, n, r);
					add_char(8'h2D, n, r);
				end
				default: ;
			endcase
		end
	endtask

	task automatic fold_step(input u2l_pkg::in_word_t w, output int n,
			output logic [3:0][7:0] r);
		logic [3:0][7:0] s;
		int h;
		int i;
		int len;
		n = 0;
		r = '0;
		s = '0;
		h = int'(held_n);
		for (i = 0; i < h; i++)
			s[i] = held[i];
		s[h] = w.in_byte;
		if (w.end_of_text) begin
			// reparse what is held, short sequences fall back to single points
			i = 0;
			while (i < h + 1) begin
				len = int'(seq_len_of(s[i]));
				if (i + len > h + 1)
					len = 1;
				add_point(point_of(s, i, len), n, r);
				i += len;
			end
			held_n = 2'd0;
			want_len = 3'd0;
		end else if (h == 0) begin
			len = int'(seq_len_of(w.in_byte));
			if (len == 1) begin
				add_point({13'd0, w.in_byte}, n, r);
			end else begin
				held[0] = w.in_byte;
				held_n = 2'd1;
				want_len = 3'(len);
			end
		end else if (h + 1 >= want_len) begin
			add_point(point_of(s, 0, h + 1), n, r);
			held_n = 2'd0;
			want_len = 3'd0;
		end else begin
			held[h] = w.in_byte;
			held_n = 2'(h + 1);
		end
	endtask

	task automatic plan(input logic [7:0] b, input logic eot, input logic known,
			input logic [2:0] n, input logic [31:0] r);
		plan_row_t row;
		row.b = b;
		row.eot = eot;
		row.known = known;
		row.n = n;
		row.r = r;
		text_plan = {text_plan, row};
	endtask

	task automatic plan_point(input logic [20:0] cp, input int len, input int cut,
			input logic eot);
		logic [3:0][7:0] u;
		int k;
		case (len)
			2: u = {16'd0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
			3: u = {8'd0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
			4: u = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
			default: u = {24'd0, cp[7:0]};
		endcase
		for (k = 0; k < cut; k++)
			plan(u[k], (k == cut - 1) ? eot : 1'b0, 1'b0, 3'd0, 32'd0);
	endtask

	function automatic logic [20:0] fold_pick(input int k);
		case (k)
			0: return 21'h002018;
			1: return 21'h002019;
			2: return 21'h00201B;
			3: return 21'h00201C;
			4: return 21'h00201D;
			5: return 21'h002013;
			6: return 21'h002014;
			7: return 21'h002212;
			8: return 21'h002026;
			9: return 21'h002022;
			10: return 21'h0025CF;
			11: return 21'h002192;
			12: return 21'h002190;
			13: return 21'h0000A0;
			14: return 21'h0000FF;
			default: return 21'h000100;
		endcase
	endfunction

	task automatic take_text(input u2l_pkg::in_word_t w);
		plan_row_t row;
		u2l_pkg::out_word_t due;
		int n;
		logic [3:0][7:0] r;
		int k;
		fold_step(w, n, r);
		row = text_plan[n_acc];
		if (row.known) begin
			n = int'(row.n);
			r = row.r;
		end
		for (k = 0; k < n; k++) begin
			due.out_byte = r[k];
			due.run_last = (k == n - 1);
			latin_due_q = {latin_due_q, due};
		end
		if (w.end_of_text)
			n_eot++;
		n_acc++;
	endtask

	always @(posedge clk) begin : drive_text
		u2l_pkg::in_word_t w;
		if (arst_n) begin
			if (text_valid && !text_stall)
				take_text(text_word);
			else if (text_valid)
				n_backpressure++;
			if (!text_valid || !text_stall) begin
				if (next_idx < text_plan.size() && (gap_left == 0 || holding)) begin
					w.in_byte = text_plan[next_idx].b;
					w.end_of_text = text_plan[next_idx].eot;
					text_word <= w;
					text_valid <= 1'b1;
					next_idx++;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					text_valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end
			end
		end
	end

	always @(posedge clk) begin : drive_stall
		rx_mode_t mode;
		if (!arst_n || tail) begin
			latin_stall <= 1'b0;
			holding <= 1'b0;
		end else begin
			rx_cycle++;
			// long hold-offs fill the run queue and push back on the input
			if (rx_cycle == 150 || rx_cycle == 1200) begin
				hold_left = (rx_cycle == 150) ? 200 : 150;
				n_holds++;
			end
			if (hold_left > 0) begin
				hold_left--;
				latin_stall <= 1'b1;
				holding <= 1'b1;
			end else begin
				holding <= 1'b0;
				mode = rx_mode_t'((rx_cycle / 64) % 4);
				case (mode)
					RX_OPEN: latin_stall <= 1'b0;
					RX_LIGHT: latin_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: latin_stall <= ($urandom_range(0, 3) != 0);
					RX_TOGGLE: latin_stall <= rx_cycle[1];
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_latin
		u2l_pkg::out_word_t due;
		if (arst_n && latin_valid && !latin_stall) begin
			n_latin++;
			if (latin_due_q.size() == 0) begin
				n_bad++;
				if (n_bad <= REPORT_MAX)
					$display("latin word %0d unexpected: byte %h last %b",
						n_latin, latin_word.out_byte, latin_word.run_last);
			end else begin
				due = latin_due_q.pop_front();
				if (latin_word.out_byte !== due.out_byte ||
						latin_word.run_last !== due.run_last) begin
					n_bad++;
					if (n_bad <= REPORT_MAX)
						$display("latin word %0d: got byte %h last %b, want byte %h last %b",
							n_latin, latin_word.out_byte, latin_word.run_last,
							due.out_byte, due.run_last);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		n_cycles <= n_cycles + 1;
		if (n_cycles >= LIMIT_CYCLES) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin : main
		int kind;
		int len;
		int cut;
		int k;
		logic [20:0] cp;
		logic [7:0] lead;
		logic eot;

		plan(8'h00, 1'b0, 1'b1, 3'd1, 32'h00000000);
		plan(8'h7F, 1'b0, 1'b1, 3'd1, 32'h0000007F);
		plan(8'h80, 1'b0, 1'b1, 3'd1, 32'h00000080);
		plan(8'hFF, 1'b0, 1'b1, 3'd1, 32'h000000FF);
		// stray nbsp byte is an invalid lead and still folds to space
		plan(8'hA0, 1'b0, 1'b1, 3'd1, 32'h00000020);
		plan(8'hC2, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'hA0, 1'b0, 1'b1, 3'd1, 32'h00000020);
		plan(8'hE2, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'h80, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'h99, 1'b0, 1'b1, 3'd1, 32'h00000027);
		plan(8'hE2, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'h80, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'hA6, 1'b0, 1'b1, 3'd3, 32'h002E2E2E);
		plan(8'hE2, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'h86, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'h92, 1'b0, 1'b1, 3'd2, 32'h00003E2D);
		// four byte point above the fold set is dropped
		plan(8'hF0, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'h9F, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'h98, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'h80, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'hC3, 1'b1, 1'b1, 3'd1, 32'h000000C3);
		plan(8'hE2, 1'b0, 1'b1, 3'd0, 32'h00000000);
		plan(8'h80, 1'b1, 1'b0, 3'd0, 32'h00000000);
		plan(8'h41, 1'b1, 1'b1, 3'd1, 32'h00000041);

		k = text_plan.size() + RANDOM_ITEMS;
		while (text_plan.size() < k) begin
			kind = $urandom_range(0, 99);
			eot = ($urandom_range(0, 9) == 0);
			if (kind < 25) begin
				plan_point(21'($urandom_range(0, 127)), 1, 1, eot);
			end else if (kind < 40) begin
				plan_point(21'($urandom_range(0, 21'h0007FF)), 2, 2, eot);
			end else if (kind < 65) begin
				cp = ($urandom_range(0, 1) == 0) ? fold_pick($urandom_range(0, 15)) :
					21'($urandom_range(0, 21'h00FFFF));
				plan_point(cp, 3, 3, eot);
			end else if (kind < 75) begin
				plan_point(21'($urandom_range(0, 21'h1FFFFF)), 4, 4, eot);
			end else if (kind < 85) begin
				// sequence cut short by the end of text
				len = $urandom_range(2, 4);
				cut = $urandom_range(1, len - 1);
				plan_point(21'($urandom_range(0, 21'h1FFFFF)), len, cut, 1'b1);
			end else if (kind < 93) begin
				plan(8'($urandom_range(0, 255)), eot, 1'b0, 3'd0, 32'd0);
			end else begin
				// lead followed by arbitrary bytes
				lead = 8'($urandom_range(8'hC0, 8'hF7));
				len = int'(seq_len_of(lead));
				plan(lead, 1'b0, 1'b0, 3'd0, 32'd0);
				for (cut = 1; cut < len; cut++)
					plan(8'($urandom_range(0, 255)), (cut == len - 1) ? eot : 1'b0,
						1'b0, 3'd0, 32'd0);
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		while (n_acc < text_plan.size())
			@(posedge clk);
		while (latin_due_q.size() != 0)
			@(posedge clk);
		tail <= 1'b1;
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d text words with %0d end-of-text marks, %0d latin words out",
			n_acc, n_eot, n_latin);
		$display("input pushed back for %0d cycles, %0d long output hold-offs, %0d mismatches",
			n_backpressure, n_holds, n_bad);
		if (n_bad == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
